@@ design/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed");

`endif

@@ design/utp_pkg.sv @@
// Types and constants for the UUID text parser.
package utp_pkg;

    localparam int UUID_BYTES = 16;
    localparam int POS_W      = 6;
    localparam int COUNT_W    = 5;

    localparam logic [POS_W-1:0] POS_MAX = 6'd63;

    // Character codes
    localparam logic [7:0] CHAR_DASH     = 8'h2D;  // '-'
    localparam logic [7:0] CHAR_ZERO     = 8'h30;  // '0'
    localparam logic [7:0] CHAR_NINE     = 8'h39;  // '9'
    localparam logic [7:0] CHAR_UC_A     = 8'h41;  // 'A'
    localparam logic [7:0] CHAR_UC_F     = 8'h46;  // 'F'
    localparam logic [7:0] CHAR_LC_A     = 8'h61;  // 'a'
    localparam logic [7:0] CHAR_LC_F     = 8'h66;  // 'f'
    localparam logic [7:0] CHAR_UC_OFS   = 8'h37;  // '7', 'A' - 10
    localparam logic [7:0] CHAR_LC_OFS   = 8'h57;  // 'W', 'a' - 10

    typedef struct packed {
        logic [7:0] text_char;
        logic       end_of_text;
    } item_t;

    typedef struct packed {
        logic [63:0] value_upper;
        logic [63:0] value_lower;
        logic        is_valid;
    } result_t;

endpackage

@@ design/utp_if.sv @@
// Channel interfaces: character input and parsed UUID output.
interface utp_in_if;
    import utp_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       end_of_text;

    modport source (output valid, output text_char, output end_of_text, input ready);
    modport sink   (input valid, input text_char, input end_of_text, output ready);
endinterface

interface utp_out_if;
    import utp_pkg::*;

    logic        valid;
    logic        ready;
    logic [63:0] value_upper;
    logic [63:0] value_lower;
    logic        is_valid;

    modport source (output valid, output value_upper, output value_lower, output is_valid,
                    input ready);
    modport sink   (input valid, input value_upper, input value_lower, input is_valid,
                    output ready);
endinterface

@@ design/utp_input_reg.sv @@
// Input register: holds one character until the parse stage takes it.
module utp_input_reg (
    input  logic          clk,
    input  logic          rst_n,
    utp_in_if.sink        text_in,
    input  logic          advance,
    output logic          item_valid,
    output utp_pkg::item_t item
);
    import utp_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // Ready whenever the slot is empty or drains this cycle
    assign text_in.ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (text_in.valid && text_in.ready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (text_in.valid && text_in.ready)
        begin
            item_reg.text_char   <= text_in.text_char;
            item_reg.end_of_text <= text_in.end_of_text;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

@@ design/utp_parse_core.sv @@
// Parse stage: pair tracking, byte packing and the per-text state.
module utp_parse_core #(
    parameter int MAX_TEXT_CHARS = 36
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  utp_pkg::item_t   item,
    input  logic             out_free,
    output logic             advance,
    output logic             result_load,
    output utp_pkg::result_t result
);
    import utp_pkg::*;

    localparam logic [POS_W-1:0] OPEN_LIMIT = POS_W'(MAX_TEXT_CHARS - 1);

    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               pair_reg, pair_next;
    logic [3:0]         nib_reg, nib_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               failed_reg, failed_next;
    logic [7:0]         store_reg [UUID_BYTES];
    logic [7:0]         store_next [UUID_BYTES];
    logic               store_we;

    logic       hex_ok;
    logic [3:0] hex_nib;
    logic       text_ok;

    // A final character waits for a free result register; others always go
    assign advance     = item_valid && (!item.end_of_text || out_free);
    assign result_load = advance && item.end_of_text;

    // Hex digit decode
    always_comb
    begin
        hex_ok  = 1'b1;
        hex_nib = 4'd0;
        case (item.text_char) inside
            [CHAR_ZERO:CHAR_NINE]: hex_nib = 4'(item.text_char - CHAR_ZERO);
            [CHAR_LC_A:CHAR_LC_F]: hex_nib = 4'(item.text_char - CHAR_LC_OFS);
            [CHAR_UC_A:CHAR_UC_F]: hex_nib = 4'(item.text_char - CHAR_UC_OFS);
            default:               hex_ok  = 1'b0;
        endcase
    end

    // Per-character state update
    always_comb
    begin
        pair_next   = pair_reg;
        nib_next    = nib_reg;
        count_next  = count_reg;
        failed_next = failed_reg;
        store_we    = 1'b0;
        if (!failed_reg)
        begin
            if (pair_reg)
            begin
                pair_next = 1'b0;
                if (!hex_ok)
                begin
                    failed_next = 1'b1;
                end
                else if (!count_reg[COUNT_W-1])
                begin
                    store_we   = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            else if (pos_reg < OPEN_LIMIT)
            begin
                if (item.text_char == CHAR_DASH)
                begin
                    pair_next = 1'b0;
                end
                else if (!hex_ok)
                begin
                    failed_next = 1'b1;
                end
                else
                begin
                    nib_next  = hex_nib;
                    pair_next = 1'b1;
                end
            end
        end
        pos_next = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;
    end

    // Byte store with the current write merged in, so the last pair is seen
    always_comb
    begin
        for (int i = 0; i < UUID_BYTES; i++)
        begin
            store_next[i] = store_reg[i];
        end
        if (store_we)
        begin
            store_next[count_reg[3:0]] = {nib_reg, hex_nib};
        end
    end

    // Result assembly for the final character
    always_comb
    begin
        text_ok = !failed_next && !pair_next && count_next[COUNT_W-1];
        result.value_upper = '0;
        result.value_lower = '0;
        result.is_valid    = text_ok;
        if (text_ok)
        begin
            for (int k = 0; k < 8; k++)
            begin
                result.value_upper[63-8*k -: 8] = store_next[k];
                result.value_lower[63-8*k -: 8] = store_next[k+8];
            end
        end
    end

    // Control state; cleared after the final character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            pair_reg   <= 1'b0;
            nib_reg    <= '0;
            count_reg  <= '0;
            failed_reg <= 1'b0;
        end
        else if (advance)
        begin
            if (item.end_of_text)
            begin
                pos_reg    <= '0;
                pair_reg   <= 1'b0;
                nib_reg    <= '0;
                count_reg  <= '0;
                failed_reg <= 1'b0;
            end
            else
            begin
                pos_reg    <= pos_next;
                pair_reg   <= pair_next;
                nib_reg    <= nib_next;
                count_reg  <= count_next;
                failed_reg <= failed_next;
            end
        end
    end

    // Packed bytes, no reset
    always_ff @(posedge clk)
    begin
        if (advance && store_we)
        begin
            store_reg[count_reg[3:0]] <= {nib_reg, hex_nib};
        end
    end

endmodule

@@ design/utp_result_reg.sv @@
// Result register: holds the parsed UUID until the sink takes it.
module utp_result_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             result_load,
    input  utp_pkg::result_t result,
    output logic             out_free,
    utp_out_if.source        uuid_out
);
    import utp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign out_free = !valid_reg || uuid_out.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (result_load)
        begin
            valid_next = 1'b1;
        end
        else if (uuid_out.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            result_reg <= result;
        end
    end

    assign uuid_out.valid       = valid_reg;
    assign uuid_out.value_upper = result_reg.value_upper;
    assign uuid_out.value_lower = result_reg.value_lower;
    assign uuid_out.is_valid    = result_reg.is_valid;

endmodule

@@ design/uuid_text_parser.sv @@
// UUID text parser, top level.
// Streams a UUID text one character per transfer and returns one 128-bit value per text,
// on the transfer that carries end_of_text. One character is taken every cycle; a
// character passes through an input register, the pair and byte logic, and (for the
// final character) a result register, which takes and presents the value when the final
// character leaves the input register. Only a final character whose result register is still occupied
// waits; it is held until the sink takes the previous value. Dashes outside a pair are
// skipped, a pair opens only below position MAX_TEXT_CHARS - 1, bytes past the
// sixteenth are dropped, and an invalid or short text gives zero with is_valid low.
module uuid_text_parser #(
    parameter int MAX_TEXT_CHARS = 36
) (
    input  logic      clk,
    input  logic      rst_n,
    utp_in_if.sink    text_in,
    utp_out_if.source uuid_out
);
    import utp_pkg::*;

    logic    item_valid;
    item_t   item;
    logic    advance;
    logic    out_free;
    logic    result_load;
    result_t result;

    utp_input_reg u_input_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_in    (text_in),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    utp_parse_core #(
        .MAX_TEXT_CHARS (MAX_TEXT_CHARS)
    ) u_parse_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item        (item),
        .out_free    (out_free),
        .advance     (advance),
        .result_load (result_load),
        .result      (result)
    );

    utp_result_reg u_result_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .result_load (result_load),
        .result      (result),
        .out_free    (out_free),
        .uuid_out    (uuid_out)
    );

endmodule

@@ design/utp_checker.sv @@
// Port-level checks on the UUID text parser, bound to the top level.
`include "assert_macros.svh"

module utp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] value_upper,
    input logic [63:0] value_lower,
    input logic        is_valid
);

    // Held result keeps its value until the transfer
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(value_upper) && $stable(value_lower) && $stable(is_valid))

    // An invalid text reports an all-zero value
    `ASSERT_IMPLY(a_invalid_zero, clk, rst_n, out_valid && !is_valid, value_upper == 64'd0 && value_lower == 64'd0)

    // Input never stalls while the result side is empty
    `ASSERT_IMPLY(a_no_stall_idle, clk, rst_n, !out_valid, in_ready)

    // Input never stalls while the sink is taking a result
    `ASSERT_IMPLY(a_no_stall_drain, clk, rst_n, out_valid && out_ready, in_ready)

endmodule

bind uuid_text_parser utp_checker u_utp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (text_in.ready),
    .out_valid   (uuid_out.valid),
    .out_ready   (uuid_out.ready),
    .value_upper (uuid_out.value_upper),
    .value_lower (uuid_out.value_lower),
    .is_valid    (uuid_out.is_valid)
);

@@ sim/uuid_text_parser_tb.sv @@
// Testbench for the UUID text parser: random and directed texts checked against a predictor.
`timescale 1ns / 100ps

module uuid_text_parser_tb;
    import utp_pkg::*;

    localparam int TEXT_MAX    = 36;
    localparam int TEXT_ITEMS  = 1550;
    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_PCT    = 8;
    // no idling on either side inside this window of cycles
    localparam int QUIET_FROM  = 500;
    localparam int QUIET_TO    = 1100;

    typedef struct {
        item_t chr;
        bit    drain_first;   // hold this transfer until every parsed UUID has come back
    } text_char_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    utp_in_if  text_in ();
    utp_out_if uuid_out ();

    uuid_text_parser #(
        .MAX_TEXT_CHARS(TEXT_MAX)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .text_in  (text_in),
        .uuid_out (uuid_out)
    );

    always #4 clk = ~clk;

    text_char_t char_queue[$];
    result_t    pending_uuids[$];
    text_char_t char_on_bus;
    int         failures    = 0;
    int         cycles      = 0;
    int         queued_chars = 0;

    // parser shadow state
    logic [POS_W-1:0]   pos_shadow   = '0;
    logic               pair_shadow  = 1'b0;
    logic [3:0]         nibble_shadow = '0;
    logic [COUNT_W-1:0] count_shadow = '0;
    logic               failed_shadow = 1'b0;
    logic [7:0]         bytes_shadow [UUID_BYTES];

    function automatic int digit_of(input logic [7:0] ch);
        if (ch >= CHAR_ZERO && ch <= CHAR_NINE)
            return int'(ch - CHAR_ZERO);
        if (ch >= CHAR_LC_A && ch <= CHAR_LC_F)
            return int'(ch - CHAR_LC_OFS);
        if (ch >= CHAR_UC_A && ch <= CHAR_UC_F)
            return int'(ch - CHAR_UC_OFS);
        return -1;
    endfunction

    function automatic logic [7:0] random_hex_char();
        int v;
        v = $urandom_range(15);
        if (v < 10)
            return CHAR_ZERO + 8'(v);
        if ($urandom_range(1) == 0)
            return CHAR_LC_A + 8'(v - 10);
        return CHAR_UC_A + 8'(v - 10);
    endfunction

    function automatic bit idle_now();
        if (cycles >= QUIET_FROM && cycles < QUIET_TO)
            return 1'b0;
        return $urandom_range(99) < IDLE_PCT;
    endfunction

    task automatic clear_parse();
        pos_shadow    = '0;
        pair_shadow   = 1'b0;
        nibble_shadow = '0;
        count_shadow  = '0;
        failed_shadow = 1'b0;
    endtask

    // Advance the shadow parser by one character; the final one yields the expected UUID
    task automatic parse_char(input item_t it);
        int      d;
        result_t r;
        d = digit_of(it.text_char);
        if (!failed_shadow) begin
            if (pair_shadow) begin
                pair_shadow = 1'b0;
                if (d < 0) begin
                    failed_shadow = 1'b1;
                end
                else if (count_shadow < UUID_BYTES) begin
                    bytes_shadow[count_shadow[3:0]] = {nibble_shadow, d[3:0]};
                    count_shadow++;
                end
            end
            else if (pos_shadow < TEXT_MAX - 1 && it.text_char != CHAR_DASH) begin
                if (d < 0) begin
                    failed_shadow = 1'b1;
                end
                else begin
                    nibble_shadow = d[3:0];
                    pair_shadow   = 1'b1;
                end
            end
        end
        if (pos_shadow != POS_MAX)
            pos_shadow++;

        if (it.end_of_text) begin
            r = '0;
            if (!failed_shadow && !pair_shadow && count_shadow == UUID_BYTES) begin
                for (int k = 0; k < 8; k++) begin
                    r.value_upper = {r.value_upper[55:0], bytes_shadow[k]};
                    r.value_lower = {r.value_lower[55:0], bytes_shadow[k + 8]};
                end
                r.is_valid = 1'b1;
            end
            pending_uuids.push_back(r);
            clear_parse();
        end
    endtask

    task automatic queue_text(input logic [7:0] chars[$], input bit drain_first);
        text_char_t tc;
        foreach (chars[i]) begin
            tc.chr.text_char   = chars[i];
            tc.chr.end_of_text = (i == chars.size() - 1);
            tc.drain_first     = drain_first && (i == 0);
            char_queue.push_back(tc);
        end
        queued_chars += chars.size();
    endtask

    // Cycle count and timeout
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Character driver
    always @(posedge clk) begin
        text_char_t nxt;
        if (rst_n) begin
            if (text_in.valid && text_in.ready)
                parse_char(char_on_bus.chr);
            if (!text_in.valid || text_in.ready) begin
                if (char_queue.size() != 0 && !idle_now()
                    && !(char_queue[0].drain_first && pending_uuids.size() != 0)) begin
                    nxt = char_queue.pop_front();
                    char_on_bus          <= nxt;
                    text_in.valid        <= 1'b1;
                    text_in.text_char    <= nxt.chr.text_char;
                    text_in.end_of_text  <= nxt.chr.end_of_text;
                end
                else begin
                    text_in.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and back-pressure
    always @(posedge clk) begin
        result_t want;
        if (rst_n) begin
            if (uuid_out.valid && uuid_out.ready) begin
                if (pending_uuids.size() == 0) begin
                    $error("unexpected result transfer: value_upper %h value_lower %h is_valid %b",
                           uuid_out.value_upper, uuid_out.value_lower, uuid_out.is_valid);
                    failures++;
                end
                else begin
                    want = pending_uuids.pop_front();
                    if (uuid_out.value_upper !== want.value_upper) begin
                        $error("value_upper: expected %h, actual %h",
                               want.value_upper, uuid_out.value_upper);
                        failures++;
                    end
                    if (uuid_out.value_lower !== want.value_lower) begin
                        $error("value_lower: expected %h, actual %h",
                               want.value_lower, uuid_out.value_lower);
                        failures++;
                    end
                    if (uuid_out.is_valid !== want.is_valid) begin
                        $error("is_valid: expected %b, actual %b",
                               want.is_valid, uuid_out.is_valid);
                        failures++;
                    end
                end
            end
            uuid_out.ready <= !idle_now();
        end
    end

    initial begin
        logic [7:0] txt[$];
        int         kind;
        int         len;
        int         n_texts;

        text_in.valid       = 1'b0;
        text_in.text_char   = '0;
        text_in.end_of_text = 1'b0;
        uuid_out.ready      = 1'b0;
        foreach (bytes_shadow[i])
            bytes_shadow[i] = '0;

        // Directed: field extremes and the short-text corner cases
        txt = '{8'h00};                   queue_text(txt, 1'b0);  // non-hex opener, low
        txt = '{8'hFF};                   queue_text(txt, 1'b0);  // non-hex opener, high
        txt = '{CHAR_DASH};               queue_text(txt, 1'b0);  // dash only, short
        txt = '{CHAR_UC_F};               queue_text(txt, 1'b0);  // pair open at end
        txt = '{"9", "z"};                queue_text(txt, 1'b0);  // bad second digit
        txt = '{"x", "1", "2"};           queue_text(txt, 1'b0);  // ignored after failure
        txt = '{"0", "f", CHAR_DASH, "A", "9"};  queue_text(txt, 1'b1);  // good pairs, short
        txt = '{"a", CHAR_DASH};          queue_text(txt, 1'b0);  // dash inside a pair

        // Random texts: mostly well-formed UUIDs, then variants, noise and broken ones
        n_texts = 0;
        while (queued_chars < TEXT_ITEMS + 12) begin
            txt.delete();
            kind = $urandom_range(99);
            if (kind < 50) begin
                // canonical 8-4-4-4-12
                for (int i = 0; i < 36; i++)
                    txt.push_back((i == 8 || i == 13 || i == 18 || i == 23) ?
                                  CHAR_DASH : random_hex_char());
            end
            else if (kind < 65) begin
                // plain 32 digits, maybe extra pairs and a late tail
                for (int i = 0; i < 32; i++)
                    txt.push_back(random_hex_char());
                len = $urandom_range(8);
                for (int i = 0; i < len; i++)
                    txt.push_back($urandom_range(3) == 0 ? 8'($urandom_range(255))
                                                         : random_hex_char());
            end
            else if (kind < 75) begin
                // long text past the position ceiling
                for (int i = 0; i < 36; i++)
                    txt.push_back((i == 8 || i == 13 || i == 18 || i == 23) ?
                                  CHAR_DASH : random_hex_char());
                len = $urandom_range(34, 1);
                for (int i = 0; i < len; i++)
                    txt.push_back(8'($urandom_range(255)));
            end
            else if (kind < 87) begin
                // noise: random bytes mixed with digits and dashes
                len = $urandom_range(40, 1);
                for (int i = 0; i < len; i++) begin
                    case ($urandom_range(2))
                        0: txt.push_back(8'($urandom_range(255)));
                        1: txt.push_back(CHAR_DASH);
                        default: txt.push_back(random_hex_char());
                    endcase
                end
            end
            else begin
                // truncated canonical UUID
                len = $urandom_range(35, 1);
                for (int i = 0; i < len; i++)
                    txt.push_back((i == 8 || i == 13 || i == 18 || i == 23) ?
                                  CHAR_DASH : random_hex_char());
            end
            // occasional single-character corruption of a structured text
            if (kind < 75 && $urandom_range(7) == 0)
                txt[$urandom_range(txt.size() - 1)] = 8'($urandom_range(255));
            queue_text(txt, (n_texts % 12) == 5);
            n_texts++;
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (char_queue.size() != 0 || text_in.valid)
            @(posedge clk);
        while (pending_uuids.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+design
design/utp_pkg.sv
design/utp_if.sv
design/utp_input_reg.sv
design/utp_parse_core.sv
design/utp_result_reg.sv
design/uuid_text_parser.sv
design/utp_checker.sv
sim/uuid_text_parser_tb.sv
